### sv/mfda_pkg.sv
// Shared types and constants of the multichannel fractional delay aligner.
// No dependencies; imported by the top level and by its port checker.
package mfda_pkg;

  localparam int LANES    = 4;
  localparam int SAMPLE_W = 24;
  localparam int DELAY_W  = 19;
  localparam int DSUM_W   = 20;  // system delay plus relative align delay
  localparam int FRAC_W   = 8;
  localparam int WHOLE_W  = DSUM_W - FRAC_W;
  localparam int GAIN_W   = 16;
  localparam int GAINS_W  = GAIN_W * LANES;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int BLEND_W  = 32;  // |sample| * 256 fits in 32 signed bits
  localparam int PROD_W   = BLEND_W + GAIN_W + 1;

  localparam logic [GAINS_W-1:0] GAINS_RESET = 64'h8000_8000_8000_8000;

  // Register indices of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYSTEM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_D = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAINS   = 3'd6;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [DELAY_W-1:0]         delay_t;
  typedef logic [DSUM_W-1:0]          dsum_t;

endpackage

### sv/multichannel_fractional_delay_align.sv
// Top level of the multichannel fractional delay aligner with per-channel gain.
// Depends on mfda_pkg for widths, register indices and sample types.
//
// Usage: one input beat carries a frame of four signed 24-bit samples
// (in_sample_a..d); one output beat returns the delayed, blended and scaled
// frame (out_sample_a..d). Both channels use valid/ready. Registers are
// written over the cfg channel (cfg_index, cfg_data), which is always ready;
// write them only while no frame is in flight.
// Each channel has its own circular store of DELAY_DEPTH samples in a
// synchronous RAM with one write and two read ports. A frame walks a fixed
// sequence: minimum align delay, channel delays, delay reduction modulo the
// store depth, RAM write and two reads, linear blend, gain and saturation.
// The block holds one frame at a time: it takes the next frame only after
// the current one has moved from the last step into the output register.
// A finished frame waits in the output register while the next frame is
// accepted; if out_ready stays low the sequence holds in its last step and
// in_ready stays low. After reset a clearing pass writes zero to every
// store entry with in_ready low; register writes are taken during the pass.
module multichannel_fractional_delay_align
  import mfda_pkg::*;
#(
  parameter int DELAY_DEPTH = 4096,
  parameter int CHANNELS    = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample_a,
  input  logic [SAMPLE_W-1:0]   in_sample_b,
  input  logic [SAMPLE_W-1:0]   in_sample_c,
  input  logic [SAMPLE_W-1:0]   in_sample_d,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_sample_a,
  output logic [SAMPLE_W-1:0]   out_sample_b,
  output logic [SAMPLE_W-1:0]   out_sample_c,
  output logic [SAMPLE_W-1:0]   out_sample_d,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = $clog2(DELAY_DEPTH);
  localparam int NSTEP = (WHOLE_W + 1 > AW) ? (WHOLE_W + 1 - AW) : 1;
  localparam int RW    = AW + NSTEP + 1;
  localparam logic [AW-1:0] LAST = AW'(DELAY_DEPTH - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MIN   = 3'd2;
  localparam logic [2:0] ST_DLY   = 3'd3;
  localparam logic [2:0] ST_MOD   = 3'd4;
  localparam logic [2:0] ST_ADDR  = 3'd5;
  localparam logic [2:0] ST_BLEND = 3'd6;
  localparam logic [2:0] ST_SCALE = 3'd7;

  logic [2:0]         state;
  logic [AW-1:0]      clr_cnt;

  logic               bypass;
  delay_t             common_delay;
  delay_t             align [LANES];
  logic [GAINS_W-1:0] channel_gains;

  delay_t             min_align_c;
  delay_t             min_align;
  logic               load_out;

  sample_t            in_smp [LANES];
  sample_t            smp    [LANES];
  sample_t            res    [LANES];

  assign in_smp[0] = in_sample_a;
  assign in_smp[1] = in_sample_b;
  assign in_smp[2] = in_sample_c;
  assign in_smp[3] = in_sample_d;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign load_out  = (state == ST_SCALE) && (!out_valid || out_ready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bypass        <= 1'b0;
      common_delay  <= '0;
      for (int c = 0; c < LANES; c++) begin
        align[c] <= '0;
      end
      channel_gains <= GAINS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index) inside
        REG_BYPASS:  bypass       <= cfg_data[0];
        REG_SYSTEM:  common_delay <= cfg_data[DELAY_W-1:0];
        REG_ALIGN_A, REG_ALIGN_B, REG_ALIGN_C, REG_ALIGN_D: begin
          align[2'(cfg_index - REG_ALIGN_A)] <= cfg_data[DELAY_W-1:0];
        end
        REG_GAINS:   channel_gains <= cfg_data;
        default: ;
      endcase
    end
  end

  // Smallest align delay over the channels that exist.
  always_comb begin
    min_align_c = '1;
    for (int c = 0; c < LANES; c++) begin
      if (c < CHANNELS && align[c] < min_align_c) begin
        min_align_c = align[c];
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE:  if (in_valid) state <= ST_MIN;
        ST_MIN:   state <= ST_DLY;
        ST_DLY:   state <= ST_MOD;
        ST_MOD:   state <= ST_ADDR;
        ST_ADDR:  state <= ST_BLEND;
        ST_BLEND: state <= ST_SCALE;
        ST_SCALE: if (load_out) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MIN) begin
      min_align <= min_align_c;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_a <= res[0];
      out_sample_b <= res[1];
      out_sample_c <= res[2];
      out_sample_d <= res[3];
    end
  end

  for (genvar c = 0; c < LANES; c++) begin : g_lane
    dsum_t                     dly;
    logic                      dz;
    logic [FRAC_W-1:0]         frac;
    logic [AW-1:0]             wm_c;
    logic [AW-1:0]             wm;
    logic [AW-1:0]             wp;
    logic [AW-1:0]             r0;
    logic [AW-1:0]             r1;
    logic [AW:0]               r0_wrap;
    logic                      fw0;
    logic                      fw1;
    logic                      store_en;
    sample_t                   rd0;
    sample_t                   rd1;
    sample_t                   s0;
    sample_t                   s1;
    logic [FRAC_W:0]           w0;
    logic signed [BLEND_W+1:0] p0;
    logic signed [BLEND_W+1:0] p1;
    logic signed [BLEND_W-1:0] v_c;
    logic signed [BLEND_W-1:0] v;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-GAIN_W-FRAC_W:0] q;
    logic [RW-1:0]             rem;

    always_ff @(posedge clk) begin
      if (state == ST_IDLE && in_valid) begin
        smp[c] <= in_smp[c];
      end
    end

    always_ff @(posedge clk) begin
      if (state == ST_DLY) begin
        dly <= DSUM_W'(common_delay) + DSUM_W'(align[c] - min_align);
      end
    end

    assign dz   = (dly == '0);
    assign frac = dly[FRAC_W-1:0];

    // Whole delay modulo the store depth by restoring subtraction.
    always_comb begin
      rem = RW'(dly[DSUM_W-1:FRAC_W]);
      for (int k = NSTEP - 1; k >= 0; k--) begin
        if (rem >= (RW'(DELAY_DEPTH) << k)) begin
          rem = rem - (RW'(DELAY_DEPTH) << k);
        end
      end
      wm_c = AW'(rem);
    end

    always_ff @(posedge clk) begin
      if (state == ST_MOD) begin
        wm <= wm_c;
      end
    end

    assign r0_wrap  = {1'b0, wp} + (AW+1)'(DELAY_DEPTH) - {1'b0, wm};
    assign r0       = (wp >= wm) ? (wp - wm) : r0_wrap[AW-1:0];
    assign r1       = (r0 == '0) ? LAST : (r0 - 1'b1);
    assign store_en = (state == ST_ADDR) && !dz && !bypass;

    // The slot written in this frame may also be one of the two taps.
    always_ff @(posedge clk) begin
      if (state == ST_ADDR) begin
        fw0 <= (r0 == wp);
        fw1 <= (r1 == wp);
      end
    end

    if (c < CHANNELS) begin : g_store
      sample_t       mem [DELAY_DEPTH];
      logic          mem_we;
      logic [AW-1:0] mem_waddr;
      sample_t       mem_wdata;

      assign mem_we    = (state == ST_CLEAR) || store_en;
      assign mem_waddr = (state == ST_CLEAR) ? clr_cnt : wp;
      assign mem_wdata = (state == ST_CLEAR) ? '0 : smp[c];

      always_ff @(posedge clk) begin
        if (mem_we) begin
          mem[mem_waddr] <= mem_wdata;
        end
        rd0 <= mem[r0];
        rd1 <= mem[r1];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          wp <= '0;
        end else if (store_en) begin
          wp <= (wp == LAST) ? '0 : (wp + 1'b1);
        end
      end
    end else begin : g_nostore
      assign rd0 = '0;
      assign rd1 = '0;
      assign wp  = '0;
    end

    assign s0  = fw0 ? smp[c] : rd0;
    assign s1  = fw1 ? smp[c] : rd1;
    assign w0  = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, frac};
    assign p0  = s0 * $signed({1'b0, w0});
    assign p1  = s1 * $signed({2'b0, frac});
    assign v_c = dz ? (BLEND_W'(smp[c]) <<< FRAC_W) : BLEND_W'(p0 + p1);

    always_ff @(posedge clk) begin
      if (state == ST_BLEND) begin
        v <= v_c;
      end
    end

    // Gain, round half up, saturate.
    assign prod = v * $signed({1'b0, channel_gains[GAIN_W*c +: GAIN_W]})
                + PROD_W'(1 << (GAIN_W + FRAC_W - 2));
    assign q    = prod[PROD_W-1:GAIN_W+FRAC_W-1];

    always_comb begin
      if (bypass || c >= CHANNELS) begin
        res[c] = smp[c];
      end else if (q > $signed((PROD_W-GAIN_W-FRAC_W+1)'((1 << (SAMPLE_W-1)) - 1))) begin
        res[c] = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (q < -$signed((PROD_W-GAIN_W-FRAC_W+1)'(1 << (SAMPLE_W-1)))) begin
        res[c] = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
        res[c] = q[SAMPLE_W-1:0];
      end
    end
  end

endmodule

### sv/mfda_checker.sv
// Port-level checker for the multichannel fractional delay aligner.
// Depends on mfda_pkg; bound to multichannel_fractional_delay_align below.
module mfda_checker
  import mfda_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_sample_a
);

  // A stalled output beat stays valid and keeps its lane a sample.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_a))
    else $error("output beat changed while stalled");

  // The clearing pass keeps the input closed right after reset.
  a_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input opened during the clearing pass");

  // One frame in flight: the input stays closed for the whole sequence.
  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready
                             ##1 !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("frame accepted while another is in flight");

  // A result only appears at the end of a frame's sequence.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("output beat without a frame in flight");

endmodule

bind multichannel_fractional_delay_align mfda_checker u_mfda_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_sample_a (out_sample_a)
);
